// File: hw/rtl/rx_chunk_generation_reassembler_macros.svh
// assertion macros for the rx chunk reassembler checker
// depends on nothing; included by the checker file
`ifndef RX_CHUNK_GENERATION_REASSEMBLER_MACROS_SVH
`define RX_CHUNK_GENERATION_REASSEMBLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RCGR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcgr check failed");

// next-cycle implication, disabled during reset
`define RCGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcgr check failed");

`endif

// File: hw/rtl/rcgr_pkg.sv
// shared types and constants of the rx chunk reassembler
// no dependencies
`default_nettype none

package rcgr_pkg;

   localparam int RING_SLOTS       = 16384;
   localparam int CHUNK_BYTES      = 120;
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int CRC_BYTES        = 4;

   localparam int SLOT_W     = $clog2(RING_SLOTS);
   localparam int COUNT_W    = 22;
   localparam int GEN_W      = 8;
   localparam int DATA_W     = 8;
   localparam int ACC_W      = 12;
   localparam int SUM_W      = ACC_W + 1;
   localparam int CODE_W     = 3;
   localparam int PLEN_W     = 12;
   localparam int END_SLOT_W = 14;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DATA_W-1:0] ERROR_MASK_RESET = 8'h0F;
   localparam logic ERROR_MASK_REG = 1'b0;

   // masked status values with a dedicated code
   localparam logic [DATA_W-1:0] STATUS_ABORTED     = 8'h01;
   localparam logic [DATA_W-1:0] STATUS_CRC_BAD     = 8'h02;
   localparam logic [DATA_W-1:0] STATUS_HW_OVERFLOW = 8'h03;

   typedef enum logic [CODE_W-1:0] {
      RC_OK          = 3'd0,
      RC_TOO_LARGE   = 3'd1,
      RC_OVERRUN     = 3'd2,
      RC_ABORTED     = 3'd3,
      RC_CRC_BAD     = 3'd4,
      RC_HW_OVERFLOW = 3'd5,
      RC_OTHER_IO    = 3'd6
   } code_type;

   typedef struct packed {
      logic [GEN_W-1:0]  gen_before;
      logic [DATA_W-1:0] chunk_len;
      logic [DATA_W-1:0] chunk_status;
      logic [GEN_W-1:0]  gen_after;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               open;
      logic [ACC_W-1:0]   accum;
      code_type           sticky;
   } state_type;

   typedef struct packed {
      logic                  valid;
      code_type              code;
      logic [PLEN_W-1:0]     packet_len;
      logic [END_SLOT_W-1:0] end_slot;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/rcgr_step.sv
// per-chunk update of the reassembly state and result forming
// depends on rcgr_pkg
`default_nettype none

module rcgr_step (
   input  wire rcgr_pkg::item_type           item,
   input  wire rcgr_pkg::state_type          state_cur,
   input  wire [rcgr_pkg::DATA_W-1:0]        error_mask,
   output rcgr_pkg::state_type               state_nxt,
   output rcgr_pkg::result_type              result
);

   logic [rcgr_pkg::SLOT_W-1:0] slot;
   logic [rcgr_pkg::GEN_W-1:0]  current;
   logic [rcgr_pkg::GEN_W-1:0]  previous;
   logic [rcgr_pkg::ACC_W-1:0]  len;
   logic [rcgr_pkg::ACC_W-1:0]  acc_base;
   logic [rcgr_pkg::ACC_W-1:0]  acc_new;
   logic [rcgr_pkg::SUM_W-1:0]  sum;
   logic [rcgr_pkg::DATA_W-1:0] masked;
   rcgr_pkg::code_type          err_base;
   rcgr_pkg::code_type          err_len;
   rcgr_pkg::code_type          err_end;

   always_comb begin
      slot     = state_cur.count[rcgr_pkg::SLOT_W-1:0];
      current  = state_cur.count[rcgr_pkg::SLOT_W +: rcgr_pkg::GEN_W];
      previous = current - rcgr_pkg::GEN_W'(1);
      len      = (item.chunk_len != '0) ? rcgr_pkg::ACC_W'(item.chunk_len)
                                        : rcgr_pkg::ACC_W'(rcgr_pkg::CHUNK_BYTES);
      acc_base = state_cur.open ? state_cur.accum : '0;
      err_base = state_cur.open ? state_cur.sticky : rcgr_pkg::RC_OK;
      sum      = {1'b0, acc_base} + {1'b0, len};

      // too-large chunk is dropped from the accumulated length
      if (sum <= rcgr_pkg::SUM_W'(rcgr_pkg::MAX_PACKET_BYTES)) begin
         acc_new = sum[rcgr_pkg::ACC_W-1:0];
         err_len = err_base;
      end else begin
         acc_new = acc_base;
         err_len = rcgr_pkg::RC_TOO_LARGE;
      end

      masked = item.chunk_status & error_mask;
      priority if (masked == '0) begin
         err_end = err_len;
      end else if (masked == rcgr_pkg::STATUS_ABORTED) begin
         err_end = rcgr_pkg::RC_ABORTED;
      end else if (masked == rcgr_pkg::STATUS_CRC_BAD) begin
         err_end = rcgr_pkg::RC_CRC_BAD;
      end else if (masked == rcgr_pkg::STATUS_HW_OVERFLOW) begin
         err_end = rcgr_pkg::RC_HW_OVERFLOW;
      end else begin
         err_end = rcgr_pkg::RC_OTHER_IO;
      end

      state_nxt         = state_cur;
      result.valid      = 1'b0;
      result.code       = err_end;
      result.end_slot   = rcgr_pkg::END_SLOT_W'(slot);
      if (err_end != rcgr_pkg::RC_OK) begin
         result.packet_len = rcgr_pkg::PLEN_W'(acc_new);
      end else if (acc_new >= rcgr_pkg::ACC_W'(rcgr_pkg::CRC_BYTES)) begin
         result.packet_len = rcgr_pkg::PLEN_W'(acc_new - rcgr_pkg::ACC_W'(rcgr_pkg::CRC_BYTES));
      end else begin
         result.packet_len = '0;
      end

      // a slot still holding last lap's generation is not ready yet
      if (item.gen_before != previous) begin
         state_nxt.count = state_cur.count + rcgr_pkg::COUNT_W'(1);
         state_nxt.accum = acc_new;
         state_nxt.open  = 1'b1;
         priority if (item.gen_after != current) begin
            state_nxt.sticky = rcgr_pkg::RC_OVERRUN;
         end else if (item.chunk_len == '0) begin
            state_nxt.sticky = err_len;
         end else begin
            state_nxt.sticky = err_end;
            state_nxt.open   = 1'b0;
            result.valid     = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rx_chunk_generation_reassembler.sv
// path: an accepted item is held in the input register, processed when the result register is free
// or being emptied, and its result is loaded into the result register that drives the rsp channel
// throughput: one item per cycle while the result channel does not stall, set by the single state update in rcgr_step
// reset: synchronous active high; clears valid flags, consumer count, open flag,
// accumulated length, sticky error, and sets error_mask to 0x0F
`default_nettype none

module rx_chunk_generation_reassembler (
   input  wire                                clock,
   input  wire                                reset,
   // chunk descriptor channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [rcgr_pkg::GEN_W-1:0]          req_gen_before,
   input  wire [rcgr_pkg::DATA_W-1:0]         req_chunk_len,
   input  wire [rcgr_pkg::DATA_W-1:0]         req_chunk_status,
   input  wire [rcgr_pkg::GEN_W-1:0]          req_gen_after,
   // packet result channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [rcgr_pkg::CODE_W-1:0]        rsp_result_code,
   output logic [rcgr_pkg::PLEN_W-1:0]        rsp_packet_len,
   output logic [rcgr_pkg::END_SLOT_W-1:0]    rsp_end_slot,
   // register port
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [rcgr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [rcgr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcgr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   // input register
   logic                       in_valid_ff;
   logic                       in_valid_in;
   rcgr_pkg::item_type         item_ff;

   // reassembly state
   rcgr_pkg::state_type        state_ff;
   rcgr_pkg::state_type        state_in;
   rcgr_pkg::state_type        state_step;
   rcgr_pkg::result_type       step_result;

   // result register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rcgr_pkg::result_type       rsp_ff;

   logic [rcgr_pkg::DATA_W-1:0] error_mask_ff;
   logic [rcgr_pkg::DATA_W-1:0] error_mask_in;

   logic process;
   logic req_take;
   logic csr_write;
   logic csr_hit;

   // process the held item when the result slot is free or being emptied
   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;
   assign req_take  = req_valid && req_ready;

   rcgr_step u_step (
      .item       (item_ff),
      .state_cur  (state_ff),
      .error_mask (error_mask_ff),
      .state_nxt  (state_step),
      .result     (step_result)
   );

   // register decode: one register, selected by the top address bit
   assign csr_hit    = (csr_paddr[rcgr_pkg::CSR_ADDR_W-1] == rcgr_pkg::ERROR_MASK_REG);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? rcgr_pkg::CSR_DATA_W'(error_mask_ff) : '0;

   always_comb begin
      in_valid_in   = req_take || (in_valid_ff && !process);
      state_in      = process ? state_step : state_ff;
      // a result leaves on rsp_ready; a processed item may refill the slot
      if (process) begin
         rsp_valid_in = step_result.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
      error_mask_in = (csr_write && csr_hit) ? csr_pwdata[rcgr_pkg::DATA_W-1:0]
                                             : error_mask_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{count: '0, open: 1'b0, accum: '0, sticky: rcgr_pkg::RC_OK};
         error_mask_ff <= rcgr_pkg::ERROR_MASK_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
         error_mask_ff <= error_mask_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= '{gen_before:   req_gen_before,
                      chunk_len:    req_chunk_len,
                      chunk_status: req_chunk_status,
                      gen_after:    req_gen_after};
      end
      if (process && step_result.valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_ff.code;
   assign rsp_packet_len  = rsp_ff.packet_len;
   assign rsp_end_slot    = rsp_ff.end_slot;

endmodule

`default_nettype wire

// File: hw/rtl/rcgr_checker.sv
// port-level checks of the rx chunk reassembler, bound to the top level
// depends on rcgr_pkg and rx_chunk_generation_reassembler_macros.svh
`default_nettype none
`include "rx_chunk_generation_reassembler_macros.svh"

module rcgr_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [rcgr_pkg::CODE_W-1:0]         rsp_result_code,
   input wire [rcgr_pkg::PLEN_W-1:0]         rsp_packet_len,
   input wire [rcgr_pkg::END_SLOT_W-1:0]     rsp_end_slot
);

   // a stalled result holds
   `RCGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_code) && $stable(rsp_packet_len) && $stable(rsp_end_slot))

   // no result right after reset
   `RCGR_ASSERT_IMPL(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

   // a good packet has its crc removed from a length within the limit
   `RCGR_ASSERT_IMPL(a_ok_len, clock, reset, rsp_valid && (rsp_result_code == rcgr_pkg::RC_OK), rsp_packet_len <= rcgr_pkg::PLEN_W'(rcgr_pkg::MAX_PACKET_BYTES - rcgr_pkg::CRC_BYTES))

   // no packet ever exceeds the limit
   `RCGR_ASSERT_IMPL(a_max_len, clock, reset, rsp_valid, rsp_packet_len <= rcgr_pkg::PLEN_W'(rcgr_pkg::MAX_PACKET_BYTES))

endmodule

bind rx_chunk_generation_reassembler rcgr_checker u_rcgr_checker (.*);

`default_nettype wire
